// ----- sv/rwph_pkg.sv -----
// ----------------------------------------------------------------------------
// rwph_pkg: shared types and constants for the rolling window hash
// Hash base and prime, Barrett reduction constant, beat payloads, register
// map and the request/response bundle of the modular multiply unit.
// ----------------------------------------------------------------------------
package rwph_pkg;

  localparam int SYM_W  = 8;
  localparam int HASH_W = 30;
  localparam int POS_W  = 16;
  localparam int WLEN_W = 12;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [HASH_W-1:0] HASH_BASE  = 30'd957123577;
  localparam logic [HASH_W-1:0] HASH_PRIME = 30'd1025434309;

  // floor(2^60 / prime), fits in 31 bits since the prime exceeds 2^29
  localparam logic [63:0] BARRETT_MU_FULL = 64'h1000_0000_0000_0000 / 64'd1025434309;
  localparam logic [31:0] BARRETT_MU      = BARRETT_MU_FULL[31:0];

  // register index, taken from paddr bit 2 (byte address 4*i)
  typedef enum logic {
    REG_WINDOW_LENGTH = 1'b0,
    REG_TOP_POWER     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             start_flag;
  } in_beat_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic [POS_W-1:0]  end_position;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] result;
  } mm_rsp_t;

endpackage

// ----- sv/rwph_ram.sv -----
// ----------------------------------------------------------------------------
// rwph_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; a read and
// a write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module rwph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rwph_mulmod.sv -----
// ----------------------------------------------------------------------------
// rwph_mulmod: iterative modular multiplier
// Computes a*b mod prime with one shared 32x32 multiplier and Barrett
// reduction: product, quotient estimate, quotient times prime, subtract,
// then one or two conditional subtractions of the prime.
// ----------------------------------------------------------------------------
module rwph_mulmod (
  input  logic             clk,
  input  logic             rst,
  input  rwph_pkg::mm_req_t req,
  output rwph_pkg::mm_rsp_t rsp
);

  import rwph_pkg::*;

  typedef enum logic [2:0] {
    MM_IDLE,
    MM_QEST,
    MM_QM,
    MM_SUB,
    MM_FIX
  } mm_state_t;

  mm_state_t   state;
  logic [63:0] prod;
  logic [31:0] p_low;
  logic [31:0] rem;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] product;
  logic        rem_ok;

  // select operands of the shared multiplier by step
  always_comb begin
    case (state)
      MM_IDLE: begin
        mul_a = {2'b00, req.a};
        mul_b = {2'b00, req.b};
      end
      MM_QEST: begin
        mul_a = prod[60:29];
        mul_b = BARRETT_MU;
      end
      MM_QM: begin
        mul_a = prod[62:31];
        mul_b = {2'b00, HASH_PRIME};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = {32'd0, mul_a} * {32'd0, mul_b};
  assign rem_ok  = (rem < {2'b00, HASH_PRIME});

  assign rsp.done   = (state == MM_FIX) && rem_ok;
  assign rsp.result = rem[HASH_W-1:0];

  // sequence the reduction steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MM_IDLE;
    end else begin
      case (state)
        MM_IDLE: begin
          if (req.start) begin
            prod  <= product;
            state <= MM_QEST;
          end
        end
        MM_QEST: begin
          p_low <= prod[31:0];
          prod  <= product;
          state <= MM_QM;
        end
        MM_QM: begin
          prod  <= product;
          state <= MM_SUB;
        end
        MM_SUB: begin
          // remainder is below three primes, so 32 bits hold it
          rem   <= p_low - prod[31:0];
          state <= MM_FIX;
        end
        MM_FIX: begin
          if (!rem_ok) begin
            rem <= rem - {2'b00, HASH_PRIME};
          end else begin
            state <= MM_IDLE;
          end
        end
        default: begin
          state <= MM_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/rolling_window_polynomial_hash_core.sv -----
// ----------------------------------------------------------------------------
// rolling_window_polynomial_hash_core: sliding window polynomial hash
// Keeps a base 957123577, prime 1025434309 hash over the last window_length
// symbols and emits the window hash and symbol position once the window
// is full.
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid/in_ready   | symbol, start_flag
//   out     | output    | out_valid/out_ready | hash_value, end_position
//   apb     | input     | psel/penable/pready | window_length, top_power
//
// A symbol takes a load step, one or two modular products through the
// shared multiplier and a finish step. in_ready is high only while the
// sequencer is idle.
// Reset clears the counters and hash; the symbol store is not cleared and
// needs no clearing pass.
// A result waits in the output register while the next symbol is taken; the
// sequencer holds at its finish step only if that next result is ready first.
// ----------------------------------------------------------------------------
module rolling_window_polynomial_hash_core #(
  parameter int MAX_WINDOW = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rwph_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rwph_pkg::out_beat_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rwph_pkg::ADDR_W-1:0]   paddr,
  input  logic [rwph_pkg::DATA_W-1:0]   pwdata,
  output logic [rwph_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  import rwph_pkg::*;

  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DROP_WAIT,
    ST_BASE_GO,
    ST_BASE_WAIT,
    ST_EMIT
  } state_t;

  state_t              state;
  logic [WLEN_W-1:0]   window_length;
  logic [HASH_W-1:0]   top_power;
  logic [HASH_W-1:0]   top_power_red;
  logic [HASH_W-1:0]   running_hash;
  logic [HASH_W-1:0]   hash_work;
  logic [LW-1:0]       fill;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_out;
  logic [AW-1:0]       wi;
  logic [SYM_W-1:0]    sym;
  logic                full_q;
  logic                emit;

  logic                accept;
  logic                cfg_we;
  logic [LW-1:0]       len_eff;
  logic [LW-1:0]       fill_base;
  logic                full;
  logic                fills_now;
  logic [POS_W-1:0]    pos_base;
  logic [31:0]         wi32;
  logic [31:0]         len32;
  logic [31:0]         old32;
  logic [AW-1:0]       raddr;
  logic [SYM_W-1:0]    rdata;
  logic                ram_we;
  mm_req_t             mm_req;
  mm_rsp_t             mm_rsp;
  logic [HASH_W:0]     drop_diff;
  logic [HASH_W:0]     drop_wrap;
  logic [HASH_W-1:0]   drop_hash;
  logic [HASH_W:0]     sym_sum;
  logic [HASH_W-1:0]   base_hash;
  logic [HASH_W-1:0]   pwdata_h;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign pwdata_h = pwdata[HASH_W-1:0];

  // clamp window length into 1..MAX_WINDOW
  always_comb begin
    if (window_length == '0) begin
      len_eff = LW'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      len_eff = LW'(MAX_WINDOW);
    end else begin
      len_eff = LW'(window_length);
    end
  end

  // fill and position as seen after a start flag
  assign fill_base = in_data.start_flag ? '0 : fill;
  assign pos_base  = in_data.start_flag ? '0 : pos;
  assign full      = (fill_base >= len_eff);
  assign fills_now = (({1'b0, fill_base} + 1'b1) == {1'b0, len_eff});

  // ring address of the symbol leaving the window
  assign wi32  = 32'(wi);
  assign len32 = 32'(len_eff);
  assign old32 = (wi32 >= len32) ? (wi32 - len32) : (wi32 + 32'(MAX_WINDOW) - len32);
  assign raddr = old32[AW-1:0];
  assign ram_we = (state == ST_LOAD);

  rwph_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi),
    .wdata (sym),
    .raddr (raddr),
    .rdata (rdata)
  );

  // drive the multiplier: oldest symbol times top power, then hash times base
  always_comb begin
    mm_req.start = ((state == ST_LOAD) && full_q) || (state == ST_BASE_GO);
    if (state == ST_LOAD) begin
      mm_req.a = HASH_W'(rdata);
      mm_req.b = top_power_red;
    end else begin
      mm_req.a = hash_work;
      mm_req.b = HASH_BASE;
    end
  end

  rwph_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  // subtract the dropped term modulo the prime
  assign drop_diff = {1'b0, hash_work} - {1'b0, mm_rsp.result};
  assign drop_wrap = drop_diff + {1'b0, HASH_PRIME};
  assign drop_hash = drop_diff[HASH_W] ? drop_wrap[HASH_W-1:0] : drop_diff[HASH_W-1:0];

  // add the new symbol modulo the prime
  assign sym_sum   = {1'b0, mm_rsp.result} + (HASH_W + 1)'(sym);
  assign base_hash = (sym_sum >= {1'b0, HASH_PRIME}) ?
                     HASH_W'(sym_sum - {1'b0, HASH_PRIME}) : sym_sum[HASH_W-1:0];

  // register read
  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_WINDOW_LENGTH: prdata = DATA_W'(window_length);
      REG_TOP_POWER:     prdata = DATA_W'(top_power);
      default:           prdata = '0;
    endcase
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= WLEN_W'(1);
      top_power     <= HASH_W'(1);
      top_power_red <= HASH_W'(1);
      running_hash  <= '0;
      fill          <= '0;
      pos           <= '0;
      wi            <= '0;
      out_valid     <= 1'b0;
    end else begin
      // drop the output beat once taken
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // configuration writes must arrive only while idle; the block itself does not enforce this
      if (cfg_we) begin
        case (reg_idx_t'(paddr[2]))
          REG_WINDOW_LENGTH: begin
            window_length <= pwdata[WLEN_W-1:0];
            fill          <= '0;
            running_hash  <= '0;
          end
          REG_TOP_POWER: begin
            top_power <= pwdata_h;
            if (pwdata_h >= HASH_PRIME) begin
              top_power_red <= pwdata_h - HASH_PRIME;
            end else begin
              top_power_red <= pwdata_h;
            end
          end
          default: begin
            top_power <= top_power;
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            sym       <= in_data.symbol;
            hash_work <= in_data.start_flag ? '0 : running_hash;
            full_q    <= full;
            emit      <= full || fills_now;
            fill      <= full ? len_eff : LW'(fill_base + 1'b1);
            pos_out   <= pos_base;
            pos       <= pos_base + 1'b1;
            state     <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // store the symbol and advance the ring
          if (32'(wi) == 32'(MAX_WINDOW - 1)) begin
            wi <= '0;
          end else begin
            wi <= wi + 1'b1;
          end
          state <= full_q ? ST_DROP_WAIT : ST_BASE_GO;
        end
        ST_DROP_WAIT: begin
          if (mm_rsp.done) begin
            hash_work <= drop_hash;
            state     <= ST_BASE_GO;
          end
        end
        ST_BASE_GO: begin
          state <= ST_BASE_WAIT;
        end
        ST_BASE_WAIT: begin
          if (mm_rsp.done) begin
            running_hash <= base_hash;
            hash_work    <= base_hash;
            state        <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!emit) begin
            state <= ST_IDLE;
          end else if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.hash_value   <= hash_work;
            out_data.end_position <= pos_out;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/rwph_checker.sv -----
// ----------------------------------------------------------------------------
// rwph_checker: port-level checks for the rolling window hash core
// Watches the beat channels of the top level and flags output stalls that
// lose data, overlapping symbols, stray results and out-of-range hashes.
// ----------------------------------------------------------------------------
module rwph_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rwph_pkg::out_beat_t out_data
);

  import rwph_pkg::*;

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // one symbol at a time: busy right after a symbol is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a symbol is in work");

  // a new result appears only as the sequencer finishes a symbol
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready) && in_ready)
    else $error("result shown outside the finish step");

  // hash stays reduced
  a_hash_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.hash_value < HASH_PRIME)
    else $error("hash value not below the prime");

endmodule

bind rolling_window_polynomial_hash_core rwph_checker u_rwph_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rolling_window_polynomial_hash_core
// Drives byte symbols through the valid/ready input and writes window_length
// and top_power over APB. A local model of the sliding window hash predicts
// each window result, and every output beat is checked against the oldest
// prediction. Covers reset defaults, short, zero and oversized windows, odd
// power values, string restarts and random streams.
// ----------------------------------------------------------------------------
module testbench;
  import rwph_pkg::*;

  localparam int WIN_MAX = 2048;
  localparam longint unsigned PRIME = 64'd1025434309;
  localparam longint unsigned BASE = 64'd957123577;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int SHOWN_ERRORS = 40;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_CHOPPY,
    SINK_BURSTY
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  rolling_window_polynomial_hash_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // model state of the hash window, mirrors the block after reset
  logic [7:0] win_bytes [WIN_MAX];
  logic [29:0] roll_hash = '0;
  logic [11:0] fill_level = '0;
  logic [15:0] str_pos = '0;
  int unsigned wr_ptr = 0;
  logic [11:0] cfg_wlen = 12'd1;
  logic [29:0] cfg_tpow = 30'd1;
  out_beat_t pending_hashes[$];

  int unsigned symbols_sent = 0;
  int unsigned hashes_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_hold = 0;
  sink_mode_t sink_mode = SINK_OPEN;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [29:0] mod_mul(input longint unsigned a, input longint unsigned b);
    return 30'((a * b) % PRIME);
  endfunction

  // base raised to n, reduced by the prime
  function automatic logic [29:0] base_power(input int unsigned n);
    longint unsigned acc;
    acc = 1;
    repeat (n) acc = mod_mul(acc, BASE);
    return 30'(acc);
  endfunction

  // random byte, biased toward the extremes
  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 7) == 0) begin
      return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    end
    return 8'($urandom);
  endfunction

  // advance the window by one symbol and queue the hash it yields, if any
  function automatic void roll_predict(input logic [7:0] sym, input logic start);
    int unsigned len;
    int unsigned old_idx;
    longint unsigned h;
    longint unsigned drop;
    out_beat_t res;
    len = (cfg_wlen == 0) ? 1 : ((cfg_wlen > WIN_MAX) ? WIN_MAX : cfg_wlen);
    if (start) begin
      fill_level = '0;
      roll_hash = '0;
      str_pos = '0;
    end
    h = roll_hash % PRIME;
    if (fill_level >= len) begin
      old_idx = (wr_ptr + WIN_MAX - len) % WIN_MAX;
      drop = mod_mul(win_bytes[old_idx], cfg_tpow % PRIME);
      h = (h + PRIME - drop) % PRIME;
      fill_level = 12'(len);
    end else begin
      fill_level = fill_level + 12'd1;
    end
    h = mod_mul(h, BASE);
    h = (h + sym) % PRIME;
    roll_hash = 30'(h);
    win_bytes[wr_ptr] = sym;
    wr_ptr = (wr_ptr + 1) % WIN_MAX;
    if (fill_level == len) begin
      res.hash_value = 30'(h);
      res.end_position = str_pos;
      pending_hashes.push_back(res);
    end
    str_pos = str_pos + 16'd1;
  endfunction

  // send one symbol beat; open a new burst after a random gap when due
  task automatic hash_symbol(input logic [7:0] sym, input logic start);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{symbol: sym, start_flag: start};
    do @(posedge clk); while (!in_ready);
    roll_predict(sym, start);
    symbols_sent++;
  endtask

  // drop valid, wait for every pending hash, then let the sequencer go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WINDOW_LENGTH: begin
        cfg_wlen = val[11:0];
        fill_level = '0;
        roll_hash = '0;
      end
      REG_TOP_POWER: cfg_tpow = val[29:0];
      default: ;
    endcase
    reg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [11:0] wlen, input logic [29:0] tpow);
    settle();
    write_reg(REG_WINDOW_LENGTH, 32'(wlen));
    write_reg(REG_TOP_POWER, 32'(tpow));
  endtask

  // defaults out of reset: window of one, power of one
  task automatic test_reset_state();
    gap_max = 0;
    sink_mode = SINK_OPEN;
    hash_symbol(8'h00, 1'b0);
    hash_symbol(8'hFF, 1'b0);
    hash_symbol(8'h5A, 1'b1);
    hash_symbol(8'hA5, 1'b0);
  endtask

  task automatic test_short_windows();
    gap_max = 3;
    sink_mode = SINK_CHOPPY;
    // full-scale symbols through a window of three
    configure(12'd3, base_power(2));
    hash_symbol(8'hFF, 1'b1);
    repeat (2) hash_symbol(8'hFF, 1'b0);
    repeat (3) hash_symbol(8'h00, 1'b0);
    // restart the string before the window fills
    hash_symbol(8'h01, 1'b1);
    hash_symbol(8'h02, 1'b0);
    hash_symbol(8'h03, 1'b1);
    hash_symbol(8'h04, 1'b0);
    hash_symbol(8'h05, 1'b0);
    // zero length behaves as one; position keeps counting
    configure(12'd0, 30'd1);
    hash_symbol(8'h80, 1'b0);
    hash_symbol(8'h01, 1'b0);
    // power above the prime is reduced on use
    configure(12'd2, 30'h3FFF_FFFF);
    hash_symbol(8'hFF, 1'b0);
    hash_symbol(8'h00, 1'b0);
    hash_symbol(8'hFF, 1'b0);
    hash_symbol(8'h7F, 1'b0);
    // power equal to the prime reduces to zero
    configure(12'd2, 30'(PRIME));
    hash_symbol(8'hC3, 1'b0);
    hash_symbol(8'h3C, 1'b0);
  endtask

  // oversized length clamps to the largest window; too few symbols to fill it
  task automatic test_wide_windows();
    logic [29:0] top;
    top = base_power(WIN_MAX - 1);
    gap_max = 0;
    sink_mode = SINK_CHOPPY;
    configure(12'd4095, top);
    hash_symbol(pick_symbol(), 1'b1);
    repeat (7) hash_symbol(pick_symbol(), 1'b0);
  endtask

  task automatic test_random_streams();
    int unsigned wlen;
    int unsigned pick;
    logic [29:0] tpow;
    for (int ph = 0; ph < 12; ph++) begin
      // rotate idling; every fourth phase runs without any
      if (ph % 4 == 0) begin
        gap_max = 0;
        sink_mode = SINK_OPEN;
      end else begin
        gap_max = $urandom_range(4, 20);
        sink_mode = (ph % 2 == 0) ? SINK_BURSTY : SINK_CHOPPY;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) wlen = 0;
      else if (pick == 1) wlen = $urandom_range(17, 64);
      else wlen = $urandom_range(1, 16);
      // mostly a matching power, sometimes any 30-bit value
      if ($urandom_range(0, 5) == 0) tpow = 30'($urandom);
      else tpow = base_power((wlen == 0) ? 0 : wlen - 1);
      configure(12'(wlen), tpow);
      hash_symbol(pick_symbol(), 1'($urandom_range(0, 1)));
      repeat (41) hash_symbol(pick_symbol(), ($urandom_range(0, 31) == 0));
    end
  endtask

  // receiver ready pattern
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      case (sink_mode)
        SINK_OPEN: out_ready <= 1'b1;
        SINK_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= !out_ready;
          sink_hold <= out_ready ? $urandom_range(0, 24) : $urandom_range(0, 5);
        end
      endcase
    end
  end

  // compare each output beat with the oldest pending hash
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      hashes_checked++;
      if (pending_hashes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= SHOWN_ERRORS) begin
          $error("unexpected beat: hash_value %0d end_position %0d",
                 out_data.hash_value, out_data.end_position);
        end
      end else begin
        want = pending_hashes.pop_front();
        if (out_data.hash_value !== want.hash_value) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOWN_ERRORS) begin
            $error("hash_value: expected %0d, got %0d", want.hash_value,
                   out_data.hash_value);
          end
        end
        if (out_data.end_position !== want.end_position) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOWN_ERRORS) begin
            $error("end_position: expected %0d, got %0d", want.end_position,
                   out_data.end_position);
          end
        end
      end
    end
  end

  // end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d hashes pending",
               QUIET_LIMIT, pending_hashes.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_short_windows();
    test_random_streams();
    test_wide_windows();
    settle();
    $display("ran %0d symbols, checked %0d window hashes, %0d register writes",
             symbols_sent, hashes_checked, reg_writes);
    $display("window lengths of 0 to 4095, string restarts and odd power values");
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- rolling_window_polynomial_hash_core.f -----
sv/rwph_pkg.sv
sv/rwph_ram.sv
sv/rwph_mulmod.sv
sv/rolling_window_polynomial_hash_core.sv
sv/rwph_checker.sv
verif/testbench.sv
